>>> hw/rtl/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
`default_nettype none

package mtep_pkg;

    // Event queue between the parser and the output stage.
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // Width of the packed result beat, padded to whole bytes.
    localparam int EventBits = 2 + 32 + 8 + 24;
    localparam int OutBytes  = (EventBits + 7) / 8;
    localparam int OutBits   = OutBytes * 8;

    // Status and meta codes.
    localparam logic [3:0] HiNoteOff   = 4'h8;
    localparam logic [3:0] HiNoteOn    = 4'h9;
    localparam logic [3:0] HiProgram   = 4'hC;
    localparam logic [3:0] HiPressure  = 4'hD;
    localparam logic [3:0] HiSystem    = 4'hF;
    localparam logic [7:0] StatMeta    = 8'hFF;
    localparam logic [7:0] MetaTempo   = 8'h51;

    // Kinds of result.
    localparam logic [1:0] KindNoteOff = 2'd0;
    localparam logic [1:0] KindNoteOn  = 2'd1;
    localparam logic [1:0] KindTempo   = 2'd2;

    typedef enum logic [3:0] {
        PH_DELTA     = 4'd0,
        PH_STATUS    = 4'd1,
        PH_NOTE      = 4'd2,
        PH_VEL       = 4'd3,
        PH_META_TYPE = 4'd4,
        PH_META_LEN  = 4'd5,
        PH_TEMPO     = 4'd6,
        PH_SKIP      = 4'd7,
        PH_SYSEX_LEN = 4'd8
    } mtep_phase_t;

    typedef struct packed {
        logic [23:0] tempo_us;
        logic [7:0]  note_number;
        logic [31:0] tick_stamp;
        logic [1:0]  event_kind;
    } mtep_event_t;

    // Write side of the event queue.
    typedef struct packed {
        logic        valid;
        mtep_event_t evt;
    } mtep_push_t;

    // Status of the event queue.
    typedef struct packed {
        logic full;
        logic empty;
    } mtep_qstat_t;

endpackage

`default_nettype wire

>>> hw/rtl/mtep_parser.sv
// Front end: byte-serial track parser that classifies events and pushes results.
`default_nettype none

module mtep_parser
    import mtep_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       track_start,
    output mtep_push_t      push
);

    mtep_phase_t ph_reg, ph_next;
    logic [31:0] dacc_reg, dacc_next;
    logic [31:0] tick_reg, tick_next;
    logic [7:0]  rs_reg, rs_next;
    logic [7:0]  ms_reg, ms_next;
    logic [7:0]  hn_reg, hn_next;
    logic [7:0]  mk_reg, mk_next;
    logic [31:0] lacc_reg, lacc_next;
    logic [31:0] skip_reg, skip_next;
    logic [23:0] tacc_reg, tacc_next;
    logic [1:0]  tseen_reg, tseen_next;

    // A track start clears everything before the byte is parsed.
    mtep_phase_t ph_c;
    logic [31:0] dacc_c, tick_c, lacc_c, skip_c;
    logic [7:0]  rs_c, ms_c, hn_c, mk_c;
    logic [23:0] tacc_c;
    logic [1:0]  tseen_c;

    assign ph_c    = track_start ? PH_DELTA : ph_reg;
    assign dacc_c  = track_start ? '0 : dacc_reg;
    assign tick_c  = track_start ? '0 : tick_reg;
    assign rs_c    = track_start ? '0 : rs_reg;
    assign ms_c    = track_start ? '0 : ms_reg;
    assign hn_c    = track_start ? '0 : hn_reg;
    assign mk_c    = track_start ? '0 : mk_reg;
    assign lacc_c  = track_start ? '0 : lacc_reg;
    assign skip_c  = track_start ? '0 : skip_reg;
    assign tacc_c  = track_start ? '0 : tacc_reg;
    assign tseen_c = track_start ? '0 : tseen_reg;

    always_comb
    begin
        logic [7:0]  msg_s;
        logic [3:0]  msg_hi;
        logic        is_data;
        logic [31:0] len_sh;
        logic [31:0] dacc_sh;
        logic [31:0] short_len;
        logic [23:0] tacc_sh;

        ph_next    = ph_c;
        dacc_next  = dacc_c;
        tick_next  = tick_c;
        rs_next    = rs_c;
        ms_next    = ms_c;
        hn_next    = hn_c;
        mk_next    = mk_c;
        lacc_next  = lacc_c;
        skip_next  = skip_c;
        tacc_next  = tacc_c;
        tseen_next = tseen_c;
        push       = '0;

        is_data   = !data_byte[7];
        msg_s     = is_data ? rs_c : data_byte;
        msg_hi    = msg_s[7:4];
        len_sh    = {lacc_c[24:0], data_byte[6:0]};
        dacc_sh   = {dacc_c[24:0], data_byte[6:0]};
        tacc_sh   = {tacc_c[15:0], data_byte};
        short_len = {24'd0, data_byte};

        unique case (ph_c)
            PH_STATUS:
            begin
                if (!is_data)
                begin
                    rs_next = data_byte;
                end
                ms_next = msg_s;
                if (msg_hi == HiNoteOff || msg_hi == HiNoteOn)
                begin
                    if (is_data)
                    begin
                        hn_next = data_byte;
                        ph_next = PH_VEL;
                    end
                    else
                    begin
                        ph_next = PH_NOTE;
                    end
                end
                else if (msg_s == StatMeta)
                begin
                    if (is_data)
                    begin
                        mk_next   = data_byte;
                        lacc_next = '0;
                        ph_next   = PH_META_LEN;
                    end
                    else
                    begin
                        ph_next = PH_META_TYPE;
                    end
                end
                else if (msg_hi == HiSystem)
                begin
                    if (is_data)
                    begin
                        // A data byte under a system status is a one-byte length.
                        lacc_next = short_len;
                        skip_next = short_len;
                        ph_next   = (data_byte == 8'd0) ? PH_DELTA : PH_SKIP;
                    end
                    else
                    begin
                        lacc_next = '0;
                        ph_next   = PH_SYSEX_LEN;
                    end
                end
                else if (msg_hi == HiProgram || msg_hi == HiPressure)
                begin
                    // One data byte; if this byte was it, the message is done.
                    skip_next = is_data ? 32'd0 : 32'd1;
                    ph_next   = is_data ? PH_DELTA : PH_SKIP;
                end
                else
                begin
                    skip_next = is_data ? 32'd1 : 32'd2;
                    ph_next   = PH_SKIP;
                end
            end
            PH_NOTE:
            begin
                hn_next = data_byte;
                ph_next = PH_VEL;
            end
            PH_VEL:
            begin
                push.valid           = 1'b1;
                push.evt.event_kind  = (ms_c[7:4] == HiNoteOn && data_byte != 8'd0)
                                       ? KindNoteOn : KindNoteOff;
                push.evt.tick_stamp  = tick_c;
                push.evt.note_number = hn_c;
                push.evt.tempo_us    = '0;
                ph_next              = PH_DELTA;
            end
            PH_META_TYPE:
            begin
                mk_next   = data_byte;
                lacc_next = '0;
                ph_next   = PH_META_LEN;
            end
            PH_META_LEN:
            begin
                lacc_next = len_sh;
                if (is_data)
                begin
                    if (mk_c == MetaTempo)
                    begin
                        tacc_next  = '0;
                        tseen_next = '0;
                        skip_next  = (len_sh > 32'd3) ? len_sh - 32'd3 : 32'd0;
                        ph_next    = PH_TEMPO;
                    end
                    else
                    begin
                        skip_next = len_sh;
                        ph_next   = (len_sh == 32'd0) ? PH_DELTA : PH_SKIP;
                    end
                end
            end
            PH_TEMPO:
            begin
                tacc_next = tacc_sh;
                if (tseen_c >= 2'd2)
                begin
                    push.valid           = 1'b1;
                    push.evt.event_kind  = KindTempo;
                    push.evt.tick_stamp  = tick_c;
                    push.evt.note_number = '0;
                    push.evt.tempo_us    = tacc_sh;
                    tseen_next           = '0;
                    ph_next              = (skip_c == 32'd0) ? PH_DELTA : PH_SKIP;
                end
                else
                begin
                    tseen_next = tseen_c + 2'd1;
                end
            end
            PH_SKIP:
            begin
                if (skip_c > 32'd1)
                begin
                    skip_next = skip_c - 32'd1;
                end
                else
                begin
                    skip_next = '0;
                    ph_next   = PH_DELTA;
                end
            end
            PH_SYSEX_LEN:
            begin
                lacc_next = len_sh;
                if (is_data)
                begin
                    skip_next = len_sh;
                    ph_next   = (len_sh == 32'd0) ? PH_DELTA : PH_SKIP;
                end
            end
            default:
            begin
                // Delta time, and any phase code that means nothing.
                ph_next = PH_DELTA;
                if (is_data)
                begin
                    tick_next = tick_c + dacc_sh;
                    dacc_next = '0;
                    ph_next   = PH_STATUS;
                end
                else
                begin
                    dacc_next = dacc_sh;
                end
            end
        endcase

        if (!accept)
        begin
            push.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= PH_DELTA;
            dacc_reg  <= '0;
            tick_reg  <= '0;
            rs_reg    <= '0;
            ms_reg    <= '0;
            hn_reg    <= '0;
            mk_reg    <= '0;
            lacc_reg  <= '0;
            skip_reg  <= '0;
            tacc_reg  <= '0;
            tseen_reg <= '0;
        end
        else if (accept)
        begin
            ph_reg    <= ph_next;
            dacc_reg  <= dacc_next;
            tick_reg  <= tick_next;
            rs_reg    <= rs_next;
            ms_reg    <= ms_next;
            hn_reg    <= hn_next;
            mk_reg    <= mk_next;
            lacc_reg  <= lacc_next;
            skip_reg  <= skip_next;
            tacc_reg  <= tacc_next;
            tseen_reg <= tseen_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mtep_queue.sv
// Short event queue between the parser and the output stage.
`default_nettype none

module mtep_queue
    import mtep_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire mtep_push_t push,
    input  wire logic  pop,
    output mtep_event_t head,
    output mtep_qstat_t stat
);

    mtep_event_t      mem [QDepth];
    logic [QAw-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAw:0]     count_reg, count_next;

    assign stat.full  = (count_reg == QDepth[QAw:0]);
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !stat.full)
        else $error("event pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("event popped from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QDepth[QAw:0])
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mtep_emitter.sv
// Back end: output register that takes events from the queue and presents result beats.
`default_nettype none

module mtep_emitter
    import mtep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mtep_event_t head,
    input  wire mtep_qstat_t stat,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [OutBits-1:0] m_axis_tdata
);

    logic        valid_reg;
    mtep_event_t evt_reg;

    assign pop = !stat.empty && (!valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            evt_reg <= head;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OutBits - EventBits){1'b0}}, evt_reg};

endmodule

`default_nettype wire

>>> hw/rtl/midi_track_event_parser.sv
// Top level of the MIDI track event parser: parser, event queue and output stage.
`default_nettype none

// The block reads the body of a MIDI track chunk one byte per beat and reports
// note-on, note-off and tempo events, each stamped with the absolute tick of
// the track (a 32-bit count that wraps). Running status is honoured, a note-on
// with velocity zero is reported as a note-off, and other channel messages,
// meta events and SysEx are skipped by their fixed or stated length. Raise
// tuser with the first body byte of each track to clear the tick count and the
// parse state. Input bytes are taken at one per clock cycle while the event
// queue has room: the parser's phase machine does one transition per byte, and a
// result enters that four-entry queue in the cycle its last byte is accepted,
// then moves on to the output register once that register is free. The input
// side stalls only while the queue is full, so a slow consumer holds up the byte
// stream once five events are pending: four in the queue and one in the output register.
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  wire logic               s_axis_tuser,   // [0] track_start
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [1:0] event_kind, [33:2] tick_stamp, [41:34] note_number, [65:42] tempo_us,
    // upper bits zero
    output logic [OutBits-1:0]      m_axis_tdata
);

    mtep_push_t  push;
    mtep_qstat_t stat;
    mtep_event_t head;
    logic        pop;
    logic        accept;

    // A beat is taken whenever the queue has room for the event it might raise.
    assign s_axis_tready = !stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mtep_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_axis_tdata),
        .track_start (s_axis_tuser),
        .push        (push)
    );

    mtep_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (stat)
    );

    mtep_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .stat          (stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> test/midi_track_event_parser_test.sv
// Self-checking testbench for the MIDI track event parser, with its own model of the byte parser.
`timescale 1ns / 1ps

// Feeds track body bytes to the parser as input beats and predicts each event in
// step with every accepted byte. A separate process takes the result beats at a
// randomly stalled pace and compares them, field by field, against the oldest
// pending prediction. A short directed part covers the field extremes, each event
// kind, over-long variable-length numbers, running status corners, short and long
// tempo metas and tracks cut off mid-event. The bulk of the run is random tracks
// built from well-formed events, with some noise bursts and truncated tracks mixed in.
module midi_track_event_parser_test;
    import mtep_pkg::*;

    // Status high nibbles that the package does not name.
    localparam logic [3:0] HiPolyPressure = 4'hA;
    localparam logic [3:0] HiControl      = 4'hB;
    localparam logic [3:0] HiPitchBend    = 4'hE;

    // A tempo meta always takes at least this many data bytes.
    localparam int TempoBytes = 3;

    // Random input beats to send after the directed part.
    localparam int RandomBeats = 1800;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;      // [7:0] data_byte
    logic               s_axis_tuser = 1'b0;    // [0] track_start
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [1:0] event_kind, [33:2] tick_stamp, [41:34] note_number, [65:42] tempo_us,
    // upper bits zero
    logic [OutBits-1:0] m_axis_tdata;

    // When set, the sender or the receiver runs without gaps.
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    int fail_count = 0;
    int beats_sent = 0;

    midi_track_event_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model: its own copy of the phase machine and accumulators.
    // ------------------------------------------------------------------
    mtep_phase_t phase_now;
    logic [31:0] delta_acc;
    logic [31:0] track_tick;
    logic [7:0]  last_status;
    logic [7:0]  message_status;
    logic [7:0]  note_held;
    logic [7:0]  meta_code;
    logic [31:0] length_acc;
    logic [31:0] bytes_to_skip;
    logic [23:0] tempo_acc;
    logic [1:0]  tempo_count;

    // Events predicted but not yet seen on the output.
    mtep_event_t pending_events[$];

    function automatic void skip_counter_reset();
        bytes_to_skip = '0;
    endfunction

    function automatic void clear_parser();
        phase_now      = PH_DELTA;
        delta_acc      = '0;
        track_tick     = '0;
        last_status    = '0;
        message_status = '0;
        note_held      = '0;
        meta_code      = '0;
        length_acc     = '0;
        skip_counter_reset();
        tempo_acc      = '0;
        tempo_count    = '0;
    endfunction

    // Skip n bytes, or go straight back to the next delta when n is zero.
    function automatic void arm_skip(input logic [31:0] n);
        bytes_to_skip = n;
        phase_now = (n == 0) ? PH_DELTA : PH_SKIP;
    endfunction

    // Decide the next phase once the status of a message is known. When the
    // message runs on the previous status, the byte in hand is its first data byte.
    function automatic void open_message(input logic [7:0] b, input bit from_data);
        logic [3:0]  hi;
        logic [31:0] n;
        hi = message_status[7:4];
        if (hi == HiNoteOff || hi == HiNoteOn)
        begin
            if (from_data)
            begin
                note_held = b;
                phase_now = PH_VEL;
            end
            else
                phase_now = PH_NOTE;
        end
        else if (message_status == StatMeta)
        begin
            if (from_data)
            begin
                meta_code  = b;
                length_acc = '0;
                phase_now  = PH_META_LEN;
            end
            else
                phase_now = PH_META_TYPE;
        end
        else if (hi == HiSystem)
        begin
            // A data byte here is taken as a single-byte length.
            length_acc = '0;
            if (from_data)
            begin
                length_acc = {24'd0, b};
                arm_skip(length_acc);
            end
            else
                phase_now = PH_SYSEX_LEN;
        end
        else
        begin
            // Other channel messages, and data with no running status yet.
            n = (hi == HiProgram || hi == HiPressure) ? 32'd1 : 32'd2;
            if (from_data)
                n = n - 1;
            arm_skip(n);
        end
    endfunction

    // Advance the model by one accepted byte and queue any event it completes.
    function automatic void parse_track_byte(input logic [7:0] b, input bit start);
        mtep_event_t ev;
        if (start)
            clear_parser();
        case (phase_now)
            PH_STATUS:
                if (b[7])
                begin
                    last_status    = b;
                    message_status = b;
                    open_message(b, 1'b0);
                end
                else
                begin
                    message_status = last_status;
                    open_message(b, 1'b1);
                end
            PH_NOTE:
            begin
                note_held = b;
                phase_now = PH_VEL;
            end
            PH_VEL:
            begin
                // A note-on with zero velocity is reported as a note-off.
                ev.event_kind  = (message_status[7:4] == HiNoteOn && b != 8'd0) ?
                                 KindNoteOn : KindNoteOff;
                ev.tick_stamp  = track_tick;
                ev.note_number = note_held;
                ev.tempo_us    = '0;
                pending_events.push_back(ev);
                phase_now = PH_DELTA;
            end
            PH_META_TYPE:
            begin
                meta_code  = b;
                length_acc = '0;
                phase_now  = PH_META_LEN;
            end
            PH_META_LEN:
            begin
                length_acc = {length_acc[24:0], b[6:0]};
                if (!b[7])
                begin
                    if (meta_code == MetaTempo)
                    begin
                        tempo_acc     = '0;
                        tempo_count   = '0;
                        bytes_to_skip = (length_acc > 32'(TempoBytes)) ?
                                        length_acc - 32'(TempoBytes) : 32'd0;
                        phase_now     = PH_TEMPO;
                    end
                    else
                        arm_skip(length_acc);
                end
            end
            PH_TEMPO:
            begin
                tempo_acc = {tempo_acc[15:0], b};
                if (tempo_count >= 2'd2)
                begin
                    ev.event_kind  = KindTempo;
                    ev.tick_stamp  = track_tick;
                    ev.note_number = '0;
                    ev.tempo_us    = tempo_acc;
                    pending_events.push_back(ev);
                    tempo_count = '0;
                    arm_skip(bytes_to_skip);
                end
                else
                    tempo_count = tempo_count + 2'd1;
            end
            PH_SKIP:
            begin
                if (bytes_to_skip != 0)
                    bytes_to_skip = bytes_to_skip - 1;
                if (bytes_to_skip == 0)
                    phase_now = PH_DELTA;
            end
            PH_SYSEX_LEN:
            begin
                length_acc = {length_acc[24:0], b[6:0]};
                if (!b[7])
                    arm_skip(length_acc);
            end
            default:
            begin
                // Delta time; bits beyond 32 fall off the top.
                delta_acc = {delta_acc[24:0], b[6:0]};
                phase_now = PH_DELTA;
                if (!b[7])
                begin
                    track_tick = track_tick + delta_acc;
                    delta_acc  = '0;
                    phase_now  = PH_STATUS;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall at random, then compare each beat taken.
    // ------------------------------------------------------------------
    function automatic void record_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
            record_failure($sformatf("%s mismatch: expected %0h, got %0h", field, want, got));
    endfunction

    function automatic void check_event(input logic [OutBits-1:0] beat);
        mtep_event_t got;
        mtep_event_t want;
        got = beat[EventBits-1:0];
        if (pending_events.size() == 0)
        begin
            record_failure($sformatf("event beat %h arrived with nothing pending", beat));
            return;
        end
        want = pending_events.pop_front();
        compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
        compare_field("tick_stamp", want.tick_stamp, got.tick_stamp);
        compare_field("note_number", 32'(want.note_number), 32'(got.note_number));
        compare_field("tempo_us", 32'(want.tempo_us), 32'(got.tempo_us));
        compare_field("padding", 32'd0, 32'(beat[OutBits-1:EventBits]));
    endfunction

    initial
    begin : result_checker
        int stall;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = recv_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            check_event(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Byte side: one beat per call, with a random gap in front.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit start);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        parse_track_byte(b, start);
        beats_sent++;
    endtask

    // Sends v as a variable-length number, after lead extra continuation bytes.
    // Those carry zero payload, or random payload when junk is set (deltas only).
    task automatic send_varlen(input logic [31:0] v, input int lead, input bit junk,
                               input bit start);
        int n;
        bit first;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
            n++;
        first = start;
        repeat (lead)
        begin
            send_byte(junk ? 8'(8'h80 | $urandom_range(0, 127)) : 8'h80, first);
            first = 1'b0;
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            send_byte({i != 0, 7'(v >> (7 * i))}, first);
            first = 1'b0;
        end
    endtask

    task automatic send_random_bytes(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_delta(input bit start);
        int          pick;
        logic [31:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            v = $urandom_range(0, 127);
        else if (pick < 8)
            v = $urandom_range(0, 16383);
        else
            v = $urandom;
        send_varlen(v, (pick == 9) ? $urandom_range(1, 3) : 0, 1'(($urandom_range(0, 1))),
                    start);
    endtask

    // One message with random content. Without an explicit status byte the
    // message runs on the previous status and its first byte must be data.
    task automatic send_message(input logic [7:0] status, input bit explicit);
        logic [3:0] hi;
        logic [7:0] kind;
        int         len;
        hi = status[7:4];
        if (explicit)
            send_byte(status, 1'b0);
        if (hi == HiNoteOff || hi == HiNoteOn)
        begin
            send_byte(explicit ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127)),
                      1'b0);
            send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                      1'b0);
        end
        else if (status == StatMeta)
        begin
            if ($urandom_range(0, 2) == 0)
                kind = MetaTempo;
            else
                kind = explicit ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
            send_byte(kind, 1'b0);
            len = $urandom_range(0, 6);
            send_varlen(len, ($urandom_range(0, 3) == 0) ? 1 : 0, 1'b0, 1'b0);
            if (kind == MetaTempo)
                send_random_bytes((len > TempoBytes) ? len : TempoBytes);
            else
                send_random_bytes(len);
        end
        else if (hi == HiSystem)
        begin
            len = $urandom_range(0, 6);
            if (explicit)
                send_varlen(len, ($urandom_range(0, 3) == 0) ? 1 : 0, 1'b0, 1'b0);
            else
                send_byte(8'(len), 1'b0);
            send_random_bytes(len);
        end
        else
        begin
            len = (hi == HiProgram || hi == HiPressure) ? 1 : 2;
            if (!explicit)
            begin
                send_byte(8'($urandom_range(0, 127)), 1'b0);
                len--;
            end
            send_random_bytes(len);
        end
    endtask

    function automatic logic [7:0] draw_status();
        logic [3:0] chan;
        chan = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 10))
            0, 1, 2: return {HiNoteOn, chan};
            3, 4:    return {HiNoteOff, chan};
            5, 6:    return StatMeta;
            7:       return {HiSystem, 4'($urandom_range(0, 14))};
            8:       return {($urandom_range(0, 1) == 0) ? HiProgram : HiPressure, chan};
            9:       return {HiPolyPressure, chan};
            default: return {($urandom_range(0, 1) == 0) ? HiControl : HiPitchBend, chan};
        endcase
    endfunction

    // A track of well-formed events, a quarter of them on running status
    // (including, straight after the start, running status that is still zero).
    task automatic send_random_track(input int events);
        logic [7:0] status_now;
        status_now = '0;
        for (int e = 0; e < events; e++)
        begin
            send_delta(e == 0);
            if ($urandom_range(0, 3) == 0)
                send_message(status_now, 1'b0);
            else
            begin
                status_now = draw_status();
                send_message(status_now, 1'b1);
            end
        end
        // Now and then the track stops in the middle of a note.
        if ($urandom_range(0, 7) == 0)
        begin
            send_delta(1'b0);
            send_byte({HiNoteOn, 4'($urandom_range(0, 15))}, 1'b0);
            send_byte(8'($urandom_range(0, 127)), 1'b0);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 24))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    endtask

    // Hold the byte stream until every predicted event has come out. The next
    // beat is always driven at a later clock edge.
    task automatic wait_for_events();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Note-on with every field at its top on channel 15, then an over-long
    // delta whose low 32 bits are all ones, a running-status note-on with
    // zero velocity (a note-off at the last tick before the wrap), and a
    // note-off after the tick count wraps to zero.
    task automatic test_note_events();
        send_byte(8'h00, 1'b1);
        send_byte({HiNoteOn, 4'hF}, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte({HiNoteOff, 4'h0}, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h40, 1'b0);
    endtask

    // A tempo meta with stated length zero still takes three bytes; one on
    // running meta status states four, so the fourth byte is skipped.
    task automatic test_tempo_events();
        send_byte(8'h00, 1'b0);
        send_byte(StatMeta, 1'b0);
        send_byte(MetaTempo, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(MetaTempo, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAB, 1'b0);
    endtask

    // A data byte before any status is a two-byte unknown message; a system
    // code takes a length; a data byte on running system status is itself the
    // length. A note closes the sequence to show the parser is back in step.
    task automatic test_status_corners();
        send_byte(8'h00, 1'b1);
        send_byte(8'h05, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte({HiSystem, 4'h3}, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hCC, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte({HiNoteOn, 4'h1}, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h50, 1'b0);
    endtask

    // A track cut off before the velocity byte; the next track start must
    // clear the tick count and the half-parsed note.
    task automatic test_track_restart();
        send_byte(8'h05, 1'b0);
        send_byte({HiNoteOn, 4'h2}, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte({HiNoteOff, 4'h2}, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Random tracks with changing flow on both sides, a pause for every
    // pending event half-way through, and occasional bursts of raw noise.
    task automatic test_random_tracks();
        int first_beat;
        bit paused;
        first_beat = beats_sent;
        paused     = 1'b0;
        while (beats_sent - first_beat < RandomBeats)
        begin
            send_steady = ($urandom_range(0, 7) == 0);
            recv_steady = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 15) == 0)
                send_noise();
            else
                send_random_track($urandom_range(1, 12));
            if (!paused && beats_sent - first_beat >= RandomBeats / 2)
            begin
                wait_for_events();
                paused = 1'b1;
            end
        end
        send_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    initial
    begin
        clear_parser();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_note_events();
        test_tempo_events();
        test_status_corners();
        test_track_restart();
        wait_for_events();
        test_random_tracks();

        // Let the last events drain, then watch a little longer for strays.
        wait_for_events();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending_events.size() == 0)
            $display("midi_track_event_parser_test passed");
        else
            $display("midi_track_event_parser_test failed");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("midi_track_event_parser_test failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_parser.sv
hw/rtl/mtep_queue.sv
hw/rtl/mtep_emitter.sv
hw/rtl/midi_track_event_parser.sv
test/midi_track_event_parser_test.sv
